// ===== rtl/dfmt_pkg.sv =====
// shared constants, descriptor type and widths for the decimal field formatter
package dfmt_pkg;

  localparam int MAX_DIGITS = 10;
  localparam int VALUE_BITS = 32;

  localparam int COUNT_W = 4;
  localparam int COL_W   = 8;
  localparam int ROW_W   = 3;
  localparam int FONT_W  = 6;
  localparam int CHAR_W  = 6;
  localparam int STEP_W  = FONT_W - 1;

  localparam int BCD_W     = MAX_DIGITS * 4;
  localparam int DIG_IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int BIT_IDX_W = $clog2(VALUE_BITS);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CHAR_SPACE = CHAR_W'(32);
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_NINE  = CHAR_W'(57);

  // one field to be converted and printed
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [COUNT_W-1:0]    count;
    logic [COL_W-1:0]      start;
    logic [ROW_W-1:0]      row;
    logic [STEP_W-1:0]     step;
  } desc_t;

endpackage

// ===== rtl/decimal_field_formatter.sv =====
// top level of the decimal field formatter
//
// input queue: value, digit_count, start_column, page and font_height are
//   taken as one word at a clock edge with push high and full low
// output queue: one word per digit position, most significant first; the
//   oldest word sits on column, row, char_code and last while empty is low
//   and leaves at an edge with pop high
// leading zeros come out as spaces; the final position is always a digit;
//   last marks the final word of a field; a zero digit_count yields nothing
// the front part saturates the count and halves the font height, then writes
//   a descriptor into a two-entry queue, so up to two fields wait while the
//   back part is busy
// the back part takes one descriptor, runs one shift-and-add-3 step per bit
//   then emits one word per cycle into the output register unless the output stalls
// the back part reads the next descriptor only once the last word of the
//   current field has been emitted, so fields do not overlap in the back part
// a stalled receiver holds the output register and the back part waits;
//   the descriptor queue keeps taking words until it fills
// rst (synchronous) empties both queues and returns the back part to idle
module decimal_field_formatter (
  input  logic                            clk,
  input  logic                            rst,
  // input word
  input  logic                            push,
  output logic                            full,
  input  logic [dfmt_pkg::VALUE_BITS-1:0] value,
  input  logic [dfmt_pkg::COUNT_W-1:0]    digit_count,
  input  logic [dfmt_pkg::COL_W-1:0]      start_column,
  input  logic [dfmt_pkg::ROW_W-1:0]      page,
  input  logic [dfmt_pkg::FONT_W-1:0]     font_height,
  // output word
  output logic                            empty,
  input  logic                            pop,
  output logic [dfmt_pkg::COL_W-1:0]      column,
  output logic [dfmt_pkg::ROW_W-1:0]      row,
  output logic [dfmt_pkg::CHAR_W-1:0]     char_code,
  output logic                            last
);

  // front to queue
  logic            q_wr;
  dfmt_pkg::desc_t q_wr_desc;
  logic            q_full;
  // queue to back
  logic            q_rd;
  dfmt_pkg::desc_t q_rd_desc;
  logic            q_empty;
  logic            out_valid;

  dfmt_front u_front (
    .value        (value),
    .digit_count  (digit_count),
    .start_column (start_column),
    .page         (page),
    .font_height  (font_height),
    .push         (push),
    .full         (full),
    .q_full       (q_full),
    .q_wr         (q_wr),
    .q_desc       (q_wr_desc)
  );

  dfmt_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_desc (q_wr_desc),
    .rd      (q_rd),
    .rd_desc (q_rd_desc),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  dfmt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_desc    (q_rd_desc),
    .q_rd      (q_rd),
    .out_valid (out_valid),
    .pop       (pop),
    .column    (column),
    .row       (row),
    .char_code (char_code),
    .last      (last)
  );

  // output register doubles as the one-deep result queue
  assign empty = !out_valid;

endmodule

// ===== rtl/dfmt_front.sv =====
// input side: count saturation, column step and dropping of empty fields
module dfmt_front (
  input  logic [dfmt_pkg::VALUE_BITS-1:0] value,
  input  logic [dfmt_pkg::COUNT_W-1:0]    digit_count,
  input  logic [dfmt_pkg::COL_W-1:0]      start_column,
  input  logic [dfmt_pkg::ROW_W-1:0]      page,
  input  logic [dfmt_pkg::FONT_W-1:0]     font_height,
  input  logic                            push,
  output logic                            full,
  input  logic                            q_full,
  output logic                            q_wr,
  output dfmt_pkg::desc_t                 q_desc
);

  logic [dfmt_pkg::COUNT_W-1:0] count_sat;

  // counts above the field limit saturate
  always_comb begin
    if (digit_count > dfmt_pkg::COUNT_W'(dfmt_pkg::MAX_DIGITS)) begin
      count_sat = dfmt_pkg::COUNT_W'(dfmt_pkg::MAX_DIGITS);
    end else begin
      count_sat = digit_count;
    end
  end

  assign full         = q_full;
  // a zero-length field is taken but produces nothing
  assign q_wr         = push && !q_full && (count_sat != '0);
  assign q_desc.value = value;
  assign q_desc.count = count_sat;
  assign q_desc.start = start_column;
  assign q_desc.row   = page;
  assign q_desc.step  = font_height[dfmt_pkg::FONT_W-1:1];

endmodule

// ===== rtl/dfmt_queue.sv =====
// short descriptor queue between the front and back parts
module dfmt_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  dfmt_pkg::desc_t wr_desc,
  input  logic            rd,
  output dfmt_pkg::desc_t rd_desc,
  output logic            q_full,
  output logic            q_empty
);

  dfmt_pkg::desc_t             mem [dfmt_pkg::QUEUE_DEPTH];
  logic [dfmt_pkg::QPTR_W-1:0] wr_ptr;
  logic [dfmt_pkg::QPTR_W-1:0] rd_ptr;
  logic [dfmt_pkg::QCNT_W-1:0] fill;
  logic                        do_wr;
  logic                        do_rd;

  assign q_full  = (fill == dfmt_pkg::QCNT_W'(dfmt_pkg::QUEUE_DEPTH));
  assign q_empty = (fill == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rd_desc = mem[rd_ptr];

  function automatic logic [dfmt_pkg::QPTR_W-1:0] ptr_inc(
    input logic [dfmt_pkg::QPTR_W-1:0] p
  );
    if (p == dfmt_pkg::QPTR_W'(dfmt_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_rd) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= dfmt_pkg::QCNT_W'(dfmt_pkg::QUEUE_DEPTH))
    else $error("queue fill beyond depth");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    q_full && !rd |=> q_full)
    else $error("full queue lost an entry without a read");

  a_empty_holds: assert property (@(posedge clk) disable iff (rst)
    q_empty && !wr |=> q_empty)
    else $error("empty queue gained an entry without a write");

endmodule

// ===== rtl/dfmt_back.sv =====
// back part: shift-and-add-3 conversion, then one character per cycle unless the output stalls
module dfmt_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  dfmt_pkg::desc_t               q_desc,
  output logic                          q_rd,
  output logic                          out_valid,
  input  logic                          pop,
  output logic [dfmt_pkg::COL_W-1:0]    column,
  output logic [dfmt_pkg::ROW_W-1:0]    row,
  output logic [dfmt_pkg::CHAR_W-1:0]   char_code,
  output logic                          last
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]                        state;
  logic [dfmt_pkg::VALUE_BITS-1:0]   shreg;
  logic [dfmt_pkg::BCD_W-1:0]        bcd;
  logic [dfmt_pkg::BCD_W-1:0]        bcd_adj;
  logic [dfmt_pkg::BIT_IDX_W-1:0]    bitcnt;
  logic [dfmt_pkg::DIG_IDX_W-1:0]    expo;
  logic [dfmt_pkg::COL_W-1:0]        col;
  logic [dfmt_pkg::ROW_W-1:0]        row_r;
  logic [dfmt_pkg::STEP_W-1:0]       step;
  logic                              shown;
  logic [3:0]                        digit;
  logic                              is_last;
  logic                              blank;
  logic                              emit;

  // digits of five or more get 3 before the doubling shift
  always_comb begin
    for (int i = 0; i < dfmt_pkg::MAX_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  assign digit   = bcd[{expo, 2'b00} +: 4];
  assign is_last = (expo == '0);
  assign blank   = !shown && !is_last && (digit == 4'd0);
  assign emit    = (state == ST_EMIT) && (!out_valid || pop);
  assign q_rd    = (state == ST_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // a new word replaces the one popped in the same cycle
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (bitcnt == '0) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit && is_last) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      shreg  <= q_desc.value;
      bcd    <= '0;
      bitcnt <= dfmt_pkg::BIT_IDX_W'(dfmt_pkg::VALUE_BITS - 1);
      expo   <= dfmt_pkg::DIG_IDX_W'(q_desc.count - 1'b1);
      col    <= q_desc.start;
      row_r  <= q_desc.row;
      step   <= q_desc.step;
      shown  <= 1'b0;
    end
    if (state == ST_CONV) begin
      bcd    <= {bcd_adj[dfmt_pkg::BCD_W-2:0], shreg[dfmt_pkg::VALUE_BITS-1]};
      shreg  <= {shreg[dfmt_pkg::VALUE_BITS-2:0], 1'b0};
      bitcnt <= bitcnt - 1'b1;
    end
    if (emit) begin
      column <= col;
      row    <= row_r;
      last   <= is_last;
      if (blank) begin
        char_code <= dfmt_pkg::CHAR_SPACE;
      end else begin
        char_code <= dfmt_pkg::CHAR_ZERO + {{(dfmt_pkg::CHAR_W-4){1'b0}}, digit};
      end
      col   <= col + {{(dfmt_pkg::COL_W-dfmt_pkg::STEP_W){1'b0}}, step};
      shown <= shown || !blank;
      expo  <= expo - 1'b1;
    end
  end

  a_last_ends_field: assert property (@(posedge clk) disable iff (rst)
    emit && is_last |=> state == ST_IDLE)
    else $error("field did not end after its last word");

  a_conv_to_emit: assert property (@(posedge clk) disable iff (rst)
    state == ST_CONV && bitcnt == '0 |=> state == ST_EMIT)
    else $error("conversion did not hand over to emit");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> char_code == dfmt_pkg::CHAR_SPACE ||
      (char_code >= dfmt_pkg::CHAR_ZERO && char_code <= dfmt_pkg::CHAR_NINE))
    else $error("character code out of range");

  a_last_is_digit: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> char_code != dfmt_pkg::CHAR_SPACE)
    else $error("final word of a field was blanked");

endmodule

// ===== tb/sv/decimal_field_formatter_tb.sv =====
// self-checking testbench for the decimal field formatter: directed and random fields
module decimal_field_formatter_tb;

  // generous cycle budget, several times the slowest legal run
  localparam int CYCLE_LIMIT = 800000;
  // cycles to wait after the last expected word, covers a zero-count field in flight
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_FIELDS = 390;

  logic                            clk;
  logic                            rst;
  logic                            push;
  logic                            full;
  logic [dfmt_pkg::VALUE_BITS-1:0] value;
  logic [dfmt_pkg::COUNT_W-1:0]    digit_count;
  logic [dfmt_pkg::COL_W-1:0]      start_column;
  logic [dfmt_pkg::ROW_W-1:0]      page;
  logic [dfmt_pkg::FONT_W-1:0]     font_height;
  logic                            empty;
  logic                            pop;
  logic [dfmt_pkg::COL_W-1:0]      column;
  logic [dfmt_pkg::ROW_W-1:0]      row;
  logic [dfmt_pkg::CHAR_W-1:0]     char_code;
  logic                            last;

  // one output word as the block should present it
  typedef struct packed {
    logic [dfmt_pkg::COL_W-1:0]  column;
    logic [dfmt_pkg::ROW_W-1:0]  row;
    logic [dfmt_pkg::CHAR_W-1:0] char_code;
    logic                        last;
  } char_word_t;

  // expected character stream and its checker
  class char_scoreboard;
    char_word_t  expected_q[$];
    int unsigned error_count;

    function new();
      error_count = 0;
    endfunction

    // expand one accepted field into its characters, most significant first
    function void add_field(logic [dfmt_pkg::VALUE_BITS-1:0] v,
                            logic [dfmt_pkg::COUNT_W-1:0] dc,
                            logic [dfmt_pkg::COL_W-1:0] sc, logic [dfmt_pkg::ROW_W-1:0] pg,
                            logic [dfmt_pkg::FONT_W-1:0] fh);
      int unsigned digit [dfmt_pkg::MAX_DIGITS];
      int unsigned rest;
      int          n;
      int          pos;
      logic [dfmt_pkg::STEP_W-1:0] stride;
      bit          shown;
      char_word_t  w;
      // digit k is the decimal digit of weight ten to the k
      rest = v;
      for (int k = 0; k < dfmt_pkg::MAX_DIGITS; k++) begin
        digit[k] = rest % 10;
        rest = rest / 10;
      end
      // counts above the field limit saturate
      n = (int'(dc) > dfmt_pkg::MAX_DIGITS) ? dfmt_pkg::MAX_DIGITS : int'(dc);
      // odd font heights round the step down
      stride = fh[dfmt_pkg::FONT_W-1:1];
      shown = 0;
      for (int t = 0; t < n; t++) begin
        pos = n - 1 - t;
        // column wraps modulo 256 through the 8-bit target
        w.column = sc + dfmt_pkg::COL_W'(stride * t);
        w.row = pg;
        w.last = (t == n - 1);
        // leading zeros blank out, but the final position always shows a digit
        if (!shown && !w.last && digit[pos] == 0) begin
          w.char_code = dfmt_pkg::CHAR_SPACE;
        end else begin
          shown = 1;
          w.char_code = dfmt_pkg::CHAR_ZERO + dfmt_pkg::CHAR_W'(digit[pos]);
        end
        expected_q.push_back(w);
      end
    endfunction

    // compare one popped word with the oldest expectation
    function void check_char(char_word_t got);
      char_word_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word expected none actual col=%0d row=%0d char=%0d last=%0d",
                 $time, got.column, got.row, got.char_code, got.last);
        error_count++;
      end else begin
        want = expected_q.pop_front();
        if (got.column !== want.column) begin
          $display("%0t: column mismatch expected %0d actual %0d",
                   $time, want.column, got.column);
          error_count++;
        end
        if (got.row !== want.row) begin
          $display("%0t: row mismatch expected %0d actual %0d", $time, want.row, got.row);
          error_count++;
        end
        if (got.char_code !== want.char_code) begin
          $display("%0t: char_code mismatch expected %0d actual %0d",
                   $time, want.char_code, got.char_code);
          error_count++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last mismatch expected %0d actual %0d", $time, want.last, got.last);
          error_count++;
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  char_scoreboard chars;

  decimal_field_formatter dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .value        (value),
    .digit_count  (digit_count),
    .start_column (start_column),
    .page         (page),
    .font_height  (font_height),
    .empty        (empty),
    .pop          (pop),
    .column       (column),
    .row          (row),
    .char_code    (char_code),
    .last         (last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // offer one field at a falling edge and hold it until an edge with full low takes it
  task automatic send_field(input logic [dfmt_pkg::VALUE_BITS-1:0] v,
                            input logic [dfmt_pkg::COUNT_W-1:0] dc,
                            input logic [dfmt_pkg::COL_W-1:0] sc,
                            input logic [dfmt_pkg::ROW_W-1:0] pg,
                            input logic [dfmt_pkg::FONT_W-1:0] fh);
    @(negedge clk);
    push <= 1'b1;
    value <= v;
    digit_count <= dc;
    start_column <= sc;
    page <= pg;
    font_height <= fh;
    forever begin
      @(posedge clk);
      if (!full) break;
    end
  endtask

  // drop push for a number of cycles between bursts
  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // hold the sender off until every expected word has been popped
  task automatic wait_drained();
    pause_sender(1);
    while (chars.pending() != 0) @(posedge clk);
  endtask

  // both handshakes are sampled at the rising edge, where the pre-edge values still hold
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) chars.add_field(value, digit_count, start_column, page, font_height);
      if (pop && !empty) chars.check_char('{column, row, char_code, last});
    end
  end

  // receiver: free-running stretches, coin-flip popping, and long stalls, chosen at random
  initial begin
    int mode;
    int span;
    pop = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      case (mode)
        0: begin
          // no stalls at all for a while
          span = $urandom_range(40, 150);
          repeat (span) begin
            @(negedge clk);
            pop <= 1'b1;
          end
        end
        1: begin
          span = $urandom_range(40, 150);
          repeat (span) begin
            @(negedge clk);
            pop <= 1'($urandom_range(0, 1));
          end
        end
        default: begin
          // long stall followed by a short pop window
          span = $urandom_range(1, 30);
          repeat (span) begin
            @(negedge clk);
            pop <= 1'b0;
          end
          span = $urandom_range(1, 10);
          repeat (span) begin
            @(negedge clk);
            pop <= 1'b1;
          end
        end
      endcase
    end
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int                              burst_left;
    int                              sel;
    int unsigned                     p10;
    logic [dfmt_pkg::VALUE_BITS-1:0] v;
    logic [dfmt_pkg::COUNT_W-1:0]    dc;

    chars = new();
    rst = 1'b1;
    push = 1'b0;
    value = '0;
    digit_count = '0;
    start_column = '0;
    page = '0;
    font_height = '0;

    // synchronous reset held from time zero, released at a falling edge
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // directed fields: value extremes, saturation, blanking, odd steps and wrap
    send_field(32'd0, 4'd10, 8'd0, 3'd0, 6'd16);           // all spaces then a single zero
    send_field(32'hFFFF_FFFF, 4'd10, 8'd255, 3'd7, 6'd63); // largest value, widest step, wrap
    send_field(32'hFFFF_FFFF, 4'd15, 8'd10, 3'd5, 6'd8);   // count saturates to ten
    send_field(32'd12345, 4'd11, 8'd3, 3'd1, 6'd9);        // saturating count with odd font
    send_field(32'd987, 4'd0, 8'd20, 3'd2, 6'd16);         // zero count, no words
    send_field(32'd0, 4'd1, 8'd200, 3'd3, 6'd32);          // single position shows zero
    send_field(32'd7, 4'd1, 8'd100, 3'd4, 6'd1);           // single digit, step of zero
    send_field(32'd1000000000, 4'd10, 8'd0, 3'd6, 6'd0);   // top digit only, zero font
    send_field(32'd12345, 4'd3, 8'd50, 3'd0, 6'd7);        // upper digits dropped
    send_field(32'd1000, 4'd3, 8'd60, 3'd1, 6'd12);        // truncated to zeros, blanked
    send_field(32'd100, 4'd5, 8'd240, 3'd2, 6'd32);        // blanking then inner zeros, wrap
    send_field(32'd1005, 4'd6, 8'd128, 3'd7, 6'd2);        // inner zeros stay digits
    send_field(32'h8000_0000, 4'd10, 8'd1, 3'd5, 6'd33);   // top bit alone, odd font height
    send_field(32'd9, 4'd10, 8'd250, 3'd3, 6'd62);         // nine spaces then a nine
    send_field(32'd4294967295, 4'd4, 8'd0, 3'd0, 6'd5);    // low four digits of the maximum
    send_field(32'd999999999, 4'd9, 8'd77, 3'd6, 6'd31);   // all nines
    send_field(32'd1, 4'd2, 8'd255, 3'd7, 6'd63);          // one blank then a one, wrap
    send_field(32'h5555_5555, 4'd12, 8'h55, 3'd5, 6'h15);  // alternating bit patterns
    send_field(32'hAAAA_AAAA, 4'd10, 8'hAA, 3'd2, 6'h2A);
    send_field(32'd0, 4'd0, 8'd0, 3'd0, 6'd0);             // all-zero word, no output

    // let everything drain before the random part starts
    wait_drained();

    burst_left = 0;
    for (int i = 0; i < RANDOM_FIELDS; i++) begin
      // value mix: full range, small numbers for blanking, powers of ten, shifted values, near the top or zero
      sel = $urandom_range(0, 5);
      case (sel)
        0: v = $urandom;
        1: v = $urandom_range(0, 9);
        2: v = $urandom_range(0, 99999);
        3: begin
          p10 = 1;
          repeat ($urandom_range(0, 9)) p10 = p10 * 10;
          v = p10 + $urandom_range(0, 2) - 1;
        end
        4: v = $urandom >> $urandom_range(0, 31);
        default: v = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3) : '0;
      endcase
      // counts mostly in range, now and then zero or above the limit
      sel = $urandom_range(0, 9);
      if (sel == 0) dc = 4'd0;
      else if (sel == 1) dc = dfmt_pkg::COUNT_W'($urandom_range(11, 15));
      else dc = dfmt_pkg::COUNT_W'($urandom_range(1, 10));

      send_field(v, dc, dfmt_pkg::COL_W'($urandom_range(0, 255)),
                 dfmt_pkg::ROW_W'($urandom_range(0, 7)),
                 dfmt_pkg::FONT_W'($urandom_range(0, 63)));

      // another full drain halfway through
      if (i == RANDOM_FIELDS / 2) begin
        wait_drained();
        burst_left = 0;
      end

      // sender bursts with random gaps; some gaps are zero so bursts run back to back
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 20));
      end else begin
        burst_left--;
      end
    end

    // all fields sent: wait for the last words, then a quiet period for stray output
    pause_sender(1);
    while (chars.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (chars.error_count == 0 && chars.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
